>>> design/itpa_pkg.sv
package itpa_pkg;

  localparam int VALUE_W     = 64;
  localparam int NARROW_BITS = 32;
  localparam int MAX_DIGITS  = 64;
  localparam int DIGIT_W     = 4;
  localparam int BASE_W      = 5;
  localparam int CNT_W       = 7;
  localparam int SHIFT_STEPS = 6;
  localparam int LVL_W       = 3;

  localparam int WIDE_LIMIT_DEF   = 64;
  localparam int NARROW_LIMIT_DEF = 32;

  localparam logic [7:0] RADIX_MIN    = 8'd2;
  localparam logic [7:0] RADIX_MAX    = 8'd16;
  localparam logic [7:0] RADIX_SIGNED = 8'd10;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] DEC_DIGITS = 8'd10;

  typedef enum logic [1:0] {
    CH_SPACE,
    CH_MINUS,
    CH_DIGIT
  } char_sel_e;

  typedef struct packed {
    logic             load;
    logic             convert;
    logic             format;
    logic             align;
    logic [LVL_W-1:0] align_lvl;
    logic             put;
    logic             emit;
    char_sel_e        sel;
  } dp_cmd_t;

  typedef struct packed {
    logic             wide;
    logic             neg;
    logic [CNT_W-1:0] pad;
    logic [CNT_W-1:0] count;
  } dp_stat_t;

  typedef struct packed {
    logic              clear;
    logic              convert;
    logic              din;
    logic [BASE_W-1:0] base;
    logic              shift;
    logic [LVL_W-1:0]  lvl;
  } row_cmd_t;

  function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [7:0] dx;
    dx = 8'(d);
    if (dx < DEC_DIGITS) begin
      return CHAR_ZERO + dx;
    end
    return CHAR_A + (dx - DEC_DIGITS);
  endfunction

endpackage

>>> design/integer_to_padded_ascii.sv
// Converts one integer per command into right-aligned ASCII characters, MSB first.
// Each command is converted bit by bit, laid out and aligned before the first character.
// A new command is accepted only once the block is idle again; the bit-serial
// conversion shifts one operand bit per cycle into the digit row.
// Characters then leave one per cycle; the receiver cannot stall the transfers.
// Reset is asynchronous and active low; it returns the block to idle at once.
module integer_to_padded_ascii #(
  parameter int WIDE_LIMIT   = itpa_pkg::WIDE_LIMIT_DEF,
  parameter int NARROW_LIMIT = itpa_pkg::NARROW_LIMIT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [itpa_pkg::VALUE_W-1:0]  value_i,
  input  logic                          is_signed_i,
  input  logic                          is_wide_i,
  input  logic [7:0]                    radix_i,
  input  logic [7:0]                    min_width_i,
  output logic                          strobe_o,
  output logic [7:0]                    character_o,
  output logic                          last_o
);

  itpa_pkg::dp_cmd_t  cmd;
  itpa_pkg::dp_stat_t stat;

  itpa_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .strobe_o (strobe_o),
    .last_o   (last_o)
  );

  itpa_datapath #(
    .WIDE_LIMIT   (WIDE_LIMIT),
    .NARROW_LIMIT (NARROW_LIMIT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .value_i     (value_i),
    .is_signed_i (is_signed_i),
    .is_wide_i   (is_wide_i),
    .radix_i     (radix_i),
    .min_width_i (min_width_i),
    .character_o (character_o)
  );

endmodule

>>> design/itpa_digit_row.sv
module itpa_digit_row (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  itpa_pkg::row_cmd_t                   row_cmd_i,
  output logic [itpa_pkg::CNT_W-1:0]           count_o,
  output logic [itpa_pkg::DIGIT_W-1:0]         top_digit_o
);

  localparam int ND     = itpa_pkg::MAX_DIGITS;
  localparam int NE     = ND + 1;
  localparam int PFX_LV = $clog2(NE);

  logic [itpa_pkg::DIGIT_W-1:0] digits_q [ND];
  logic [itpa_pkg::DIGIT_W-1:0] digits_d [ND];
  logic [itpa_pkg::CNT_W-1:0]   n_q, n_d;

  logic [NE-1:0] g_lv [PFX_LV+1];
  logic [NE-1:0] p_lv [PFX_LV+1];
  logic [NE-1:0] carry;
  logic [itpa_pkg::DIGIT_W-1:0] conv_digit [ND];

  // Shifting one operand bit into the digit row doubles every digit. A digit
  // generates a carry when twice its value reaches the base and passes one
  // on when twice its value plus one equals the base, so the carries resolve
  // through a parallel prefix like an adder's.
  always_comb begin
    logic [itpa_pkg::BASE_W-1:0] dbl;
    logic [itpa_pkg::BASE_W-1:0] sum;
    dbl = '0;
    sum = '0;
    g_lv[0][0] = row_cmd_i.din;
    p_lv[0][0] = 1'b0;
    for (int i = 0; i < ND; i++) begin
      dbl = {digits_q[i], 1'b0};
      g_lv[0][i+1] = (dbl >= row_cmd_i.base);
      p_lv[0][i+1] = ({digits_q[i], 1'b1} == row_cmd_i.base);
    end
    for (int l = 0; l < PFX_LV; l++) begin
      for (int i = 0; i < NE; i++) begin
        if (i >= (1 << l)) begin
          g_lv[l+1][i] = g_lv[l][i] | (p_lv[l][i] & g_lv[l][i-(1<<l)]);
          p_lv[l+1][i] = p_lv[l][i] & p_lv[l][i-(1<<l)];
        end else begin
          g_lv[l+1][i] = g_lv[l][i];
          p_lv[l+1][i] = p_lv[l][i];
        end
      end
    end
    carry = g_lv[PFX_LV];
    for (int i = 0; i < ND; i++) begin
      dbl = {digits_q[i], 1'b0};
      sum = dbl + itpa_pkg::BASE_W'(carry[i])
            - (carry[i+1] ? row_cmd_i.base : itpa_pkg::BASE_W'(0));
      conv_digit[i] = sum[itpa_pkg::DIGIT_W-1:0];
    end
  end

  always_comb begin
    digits_d = digits_q;
    n_d      = n_q;
    if (row_cmd_i.clear) begin
      for (int i = 0; i < ND; i++) begin
        digits_d[i] = '0;
      end
      n_d = '0;
    end else if (row_cmd_i.convert) begin
      digits_d = conv_digit;
      // The digit just above the top nonzero one only ever receives a carry.
      n_d = n_q + itpa_pkg::CNT_W'(carry[n_q]);
    end else if (row_cmd_i.shift) begin
      for (int i = 0; i < ND; i++) begin
        for (int l = 0; l < itpa_pkg::SHIFT_STEPS; l++) begin
          if (row_cmd_i.lvl == itpa_pkg::LVL_W'(l)) begin
            digits_d[i] = (i >= (1 << l)) ? digits_q[i-(1<<l)] : '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    digits_q <= digits_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= '0;
    end else begin
      n_q <= n_d;
    end
  end

  assign count_o     = n_q;
  assign top_digit_o = digits_q[ND-1];

endmodule

>>> design/itpa_ctrl.sv
module itpa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  itpa_pkg::dp_stat_t  stat_i,
  output itpa_pkg::dp_cmd_t   cmd_o,
  output logic                strobe_o,
  output logic                last_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_FMT,
    ST_ALIGN,
    ST_PAD,
    ST_SIGN,
    ST_DIGITS
  } state_e;

  state_e                     state_q, state_d;
  logic [itpa_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                       strobe_q, strobe_d;
  logic                       last_q, last_d;
  logic [itpa_pkg::CNT_W-1:0] conv_end;

  assign conv_end = stat_i.wide ? itpa_pkg::CNT_W'(itpa_pkg::VALUE_W - 1)
                                : itpa_pkg::CNT_W'(itpa_pkg::NARROW_BITS - 1);

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    strobe_d = 1'b0;
    last_d   = 1'b0;
    cmd_o    = '0;
    cmd_o.sel = itpa_pkg::CH_SPACE;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd_o.convert = 1'b1;
        cnt_d         = cnt_q + itpa_pkg::CNT_W'(1);
        if (cnt_q == conv_end) begin
          state_d = ST_FMT;
        end
      end
      ST_FMT: begin
        cmd_o.format = 1'b1;
        cnt_d        = '0;
        state_d      = ST_ALIGN;
      end
      ST_ALIGN: begin
        cmd_o.align     = 1'b1;
        cmd_o.align_lvl = cnt_q[itpa_pkg::LVL_W-1:0];
        cnt_d           = cnt_q + itpa_pkg::CNT_W'(1);
        if (cnt_q == itpa_pkg::CNT_W'(itpa_pkg::SHIFT_STEPS - 1)) begin
          if (stat_i.pad != '0) begin
            cnt_d   = stat_i.pad;
            state_d = ST_PAD;
          end else if (stat_i.neg) begin
            state_d = ST_SIGN;
          end else begin
            cnt_d   = stat_i.count;
            state_d = ST_DIGITS;
          end
        end
      end
      ST_PAD: begin
        cmd_o.put = 1'b1;
        cmd_o.sel = itpa_pkg::CH_SPACE;
        strobe_d  = 1'b1;
        cnt_d     = cnt_q - itpa_pkg::CNT_W'(1);
        if (cnt_q == itpa_pkg::CNT_W'(1)) begin
          if (stat_i.neg) begin
            state_d = ST_SIGN;
          end else begin
            cnt_d   = stat_i.count;
            state_d = ST_DIGITS;
          end
        end
      end
      ST_SIGN: begin
        cmd_o.put = 1'b1;
        cmd_o.sel = itpa_pkg::CH_MINUS;
        strobe_d  = 1'b1;
        cnt_d     = stat_i.count;
        state_d   = ST_DIGITS;
      end
      ST_DIGITS: begin
        cmd_o.put  = 1'b1;
        cmd_o.emit = 1'b1;
        cmd_o.sel  = itpa_pkg::CH_DIGIT;
        strobe_d   = 1'b1;
        cnt_d      = cnt_q - itpa_pkg::CNT_W'(1);
        if (cnt_q == itpa_pkg::CNT_W'(1)) begin
          last_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      strobe_q <= strobe_d;
      last_q   <= last_d;
    end
  end

  assign busy     = (state_q != ST_IDLE);
  assign strobe_o = strobe_q;
  assign last_o   = last_q;

endmodule

>>> design/itpa_datapath.sv
module itpa_datapath #(
  parameter int WIDE_LIMIT   = itpa_pkg::WIDE_LIMIT_DEF,
  parameter int NARROW_LIMIT = itpa_pkg::NARROW_LIMIT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  itpa_pkg::dp_cmd_t             cmd_i,
  output itpa_pkg::dp_stat_t            stat_o,
  input  logic [itpa_pkg::VALUE_W-1:0]  value_i,
  input  logic                          is_signed_i,
  input  logic                          is_wide_i,
  input  logic [7:0]                    radix_i,
  input  logic [7:0]                    min_width_i,
  output logic [7:0]                    character_o
);

  localparam int VW = itpa_pkg::VALUE_W;
  localparam int NB = itpa_pkg::NARROW_BITS;
  localparam int CW = itpa_pkg::CNT_W;

  logic [VW-1:0]                sh_q, sh_d;
  logic [itpa_pkg::BASE_W-1:0]  base_q, base_in;
  logic                         wide_q, neg_q;
  logic [CW-1:0]                mw_q, mw_in;
  logic [CW-1:0]                count_q, pad_q;
  logic [itpa_pkg::SHIFT_STEPS-1:0] shamt_q;
  logic [7:0]                   char_q;

  logic [CW-1:0]                lim_in, lim;
  logic                         top_in, neg_in;
  logic [VW-1:0]                v_in, mag_in;

  logic [CW-1:0]                n_row, cnt_raw, count_f, len_f, pad_f, shamt_f;
  logic                         neg_f;
  logic [itpa_pkg::DIGIT_W-1:0] top_digit;
  itpa_pkg::row_cmd_t           row_cmd;

  // Operand capture: a negative signed decimal value is converted as its
  // wrapped magnitude; a narrow operand sits at the top of the shift register.
  assign lim_in  = is_wide_i ? CW'(WIDE_LIMIT) : CW'(NARROW_LIMIT);
  assign top_in  = is_wide_i ? value_i[VW-1] : value_i[NB-1];
  assign neg_in  = is_signed_i && (radix_i == itpa_pkg::RADIX_SIGNED) && top_in;
  assign v_in    = is_wide_i ? value_i : VW'(value_i[NB-1:0]);
  assign mag_in  = neg_in ? (VW'(0) - v_in) : v_in;
  assign sh_d    = is_wide_i ? mag_in : {mag_in[NB-1:0], {(VW-NB){1'b0}}};
  assign mw_in   = ({1'b0, lim_in} < min_width_i) ? lim_in : min_width_i[CW-1:0];

  always_comb begin
    if (radix_i < itpa_pkg::RADIX_MIN) begin
      base_in = itpa_pkg::BASE_W'(itpa_pkg::RADIX_MIN);
    end else if (radix_i > itpa_pkg::RADIX_MAX) begin
      base_in = itpa_pkg::BASE_W'(itpa_pkg::RADIX_MAX);
    end else begin
      base_in = radix_i[itpa_pkg::BASE_W-1:0];
    end
  end

  // Field layout once the digits are known. Digits past the limit are
  // dropped from the top, and the sign is dropped when the digits fill it.
  assign lim     = wide_q ? CW'(WIDE_LIMIT) : CW'(NARROW_LIMIT);
  assign cnt_raw = (n_row == '0) ? CW'(1) : n_row;
  assign count_f = (cnt_raw > lim) ? lim : cnt_raw;
  assign neg_f   = neg_q && (count_f < lim);
  assign len_f   = count_f + CW'(neg_f);
  assign pad_f   = (mw_q > len_f) ? (mw_q - len_f) : '0;
  assign shamt_f = CW'(itpa_pkg::MAX_DIGITS) - count_f;

  assign row_cmd.clear   = cmd_i.load;
  assign row_cmd.convert = cmd_i.convert;
  assign row_cmd.din     = sh_q[VW-1];
  assign row_cmd.base    = base_q;
  assign row_cmd.shift   = (cmd_i.align && shamt_q[cmd_i.align_lvl]) || cmd_i.emit;
  assign row_cmd.lvl     = cmd_i.emit ? '0 : cmd_i.align_lvl;

  itpa_digit_row u_row (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .row_cmd_i   (row_cmd),
    .count_o     (n_row),
    .top_digit_o (top_digit)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sh_q   <= sh_d;
      base_q <= base_in;
      mw_q   <= mw_in;
    end else if (cmd_i.convert) begin
      sh_q <= {sh_q[VW-2:0], 1'b0};
    end
    if (cmd_i.format) begin
      count_q <= count_f;
      pad_q   <= pad_f;
      shamt_q <= shamt_f[itpa_pkg::SHIFT_STEPS-1:0];
    end
    if (cmd_i.put) begin
      case (cmd_i.sel)
        itpa_pkg::CH_MINUS: char_q <= itpa_pkg::CHAR_MINUS;
        itpa_pkg::CH_DIGIT: char_q <= itpa_pkg::digit_char(top_digit);
        default:            char_q <= itpa_pkg::CHAR_SPACE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wide_q <= 1'b0;
      neg_q  <= 1'b0;
    end else if (cmd_i.load) begin
      wide_q <= is_wide_i;
      neg_q  <= neg_in;
    end else if (cmd_i.format) begin
      neg_q <= neg_f;
    end
  end

  assign stat_o.wide  = wide_q;
  assign stat_o.neg   = neg_q;
  assign stat_o.pad   = pad_q;
  assign stat_o.count = count_q;
  assign character_o  = char_q;

endmodule

>>> design/itpa_checker.sv
module itpa_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic strobe_o,
  input logic last_o
);

  // An accepted command keeps the block busy while it converts.
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("block not busy after an accepted command");

  // Conversion always precedes the first character transfer.
  a_no_early_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> !strobe_o)
    else $error("character transfer right after acceptance");

  // The final character ends the stream.
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && last_o |=> !strobe_o)
    else $error("character transfer after the final one");

  // Only the final character can be shown while the block is idle.
  a_idle_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !busy |-> last_o)
    else $error("non-final character while idle");

  a_last_has_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> strobe_o)
    else $error("last flag without a character transfer");

endmodule

bind integer_to_padded_ascii itpa_checker u_itpa_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .strobe_o (strobe_o),
  .last_o   (last_o)
);

>>> dv/tb_integer_to_padded_ascii.sv
module tb_integer_to_padded_ascii;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIDE_LIM     = itpa_pkg::WIDE_LIMIT_DEF;
  localparam int NARROW_LIM   = itpa_pkg::NARROW_LIMIT_DEF;
  localparam int STALL_LIMIT  = 1000;
  localparam int TAIL_CYCLES  = 100;
  localparam int RANDOM_ITEMS = 345;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } ascii_char_t;

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         start       = 1'b0;
  logic                         busy;
  logic [itpa_pkg::VALUE_W-1:0] value_i     = '0;
  logic                         is_signed_i = 1'b0;
  logic                         is_wide_i   = 1'b0;
  logic [7:0]                   radix_i     = 8'd10;
  logic [7:0]                   min_width_i = '0;
  logic                         strobe_o;
  logic [7:0]                   character_o;
  logic                         last_o;

  ascii_char_t pending_chars[$];
  int unsigned mismatch_count = 0;
  int unsigned stall_cycles   = 0;
  bit          idle_on        = 1'b1;

  integer_to_padded_ascii #(
    .WIDE_LIMIT  (WIDE_LIM),
    .NARROW_LIMIT(NARROW_LIM)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .value_i    (value_i),
    .is_signed_i(is_signed_i),
    .is_wide_i  (is_wide_i),
    .radix_i    (radix_i),
    .min_width_i(min_width_i),
    .strobe_o   (strobe_o),
    .character_o(character_o),
    .last_o     (last_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Works out the characters one number turns into and queues them.
  function automatic void predict_number(input logic [63:0] value, input logic sgn,
                                         input logic wide, input logic [7:0] radix,
                                         input logic [7:0] min_width);
    int unsigned lim;
    int unsigned base;
    int unsigned field;
    int unsigned ndig;
    int unsigned len;
    int unsigned pad;
    logic [63:0] mag;
    logic [63:0] quo;
    logic [3:0]  digits[64];
    logic        neg;
    ascii_char_t chars[$];
    ascii_char_t c;
    lim = wide ? WIDE_LIM : NARROW_LIM;
    if (lim > itpa_pkg::MAX_DIGITS) lim = itpa_pkg::MAX_DIGITS;
    if (lim < 1) lim = 1;
    if (radix < itpa_pkg::RADIX_MIN) base = itpa_pkg::RADIX_MIN;
    else if (radix > itpa_pkg::RADIX_MAX) base = itpa_pkg::RADIX_MAX;
    else base = radix;
    field = (min_width > lim) ? lim : min_width;
    mag = wide ? value : {32'h0, value[31:0]};
    neg = 1'b0;
    // Only a signed base-ten operand with its top bit set gets a sign.
    if (sgn && radix == itpa_pkg::RADIX_SIGNED && (wide ? mag[63] : mag[31])) begin
      neg = 1'b1;
      mag = -mag;
      if (!wide) mag[63:32] = '0;
    end
    ndig = 0;
    do begin
      quo = mag / 64'(base);
      digits[ndig % itpa_pkg::MAX_DIGITS] = 4'(mag - quo * 64'(base));
      ndig++;
      mag = quo;
    end while (mag != 0 && ndig < lim);
    if (neg && ndig >= lim) neg = 1'b0;
    len = ndig + (neg ? 1 : 0);
    pad = (len > field) ? 0 : field - len;
    c.last = 1'b0;
    for (int k = 0; k < pad; k++) begin
      c.code = itpa_pkg::CHAR_SPACE;
      chars.push_back(c);
    end
    if (neg) begin
      c.code = itpa_pkg::CHAR_MINUS;
      chars.push_back(c);
    end
    for (int k = ndig; k > 0; k--) begin
      c.code = (digits[(k - 1) % itpa_pkg::MAX_DIGITS] < 4'd10) ?
               itpa_pkg::CHAR_ZERO + 8'(digits[(k - 1) % itpa_pkg::MAX_DIGITS]) :
               itpa_pkg::CHAR_A + 8'(digits[(k - 1) % itpa_pkg::MAX_DIGITS]) - 8'd10;
      chars.push_back(c);
    end
    chars[chars.size() - 1].last = 1'b1;
    foreach (chars[i]) pending_chars.push_back(chars[i]);
  endfunction

  // Called right after a rising edge; returns right after the accepting edge.
  task automatic send_number(input logic [63:0] value, input logic sgn, input logic wide,
                             input logic [7:0] radix, input logic [7:0] min_width);
    if (idle_on && $urandom_range(0, 99) < 18) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start       <= 1'b1;
    value_i     <= value;
    is_signed_i <= sgn;
    is_wide_i   <= wide;
    radix_i     <= radix;
    min_width_i <= min_width;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    predict_number(value, sgn, wide, radix, min_width);
  endtask

  task automatic wait_for_drain();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_chars.size() != 0);
  endtask

  task automatic test_zero_and_extremes();
    send_number(64'h0, 1'b0, 1'b0, 8'd10, 8'd0);
    send_number(64'h0, 1'b0, 1'b1, 8'd16, 8'd0);
    send_number('1, 1'b0, 1'b1, 8'd2, 8'd0);
    send_number('1, 1'b0, 1'b1, 8'd10, 8'd0);
    send_number(64'hFEDC_BA98_7654_3210, 1'b0, 1'b1, 8'd16, 8'd0);
    // A narrow operand must ignore the upper half of the value.
    send_number(64'hDEAD_BEEF_1234_5678, 1'b0, 1'b0, 8'd16, 8'd0);
  endtask

  task automatic test_radix_clamp();
    send_number(64'd5, 1'b0, 1'b0, 8'd0, 8'd0);
    send_number(64'd5, 1'b0, 1'b0, 8'd1, 8'd0);
    send_number(64'd1234, 1'b0, 1'b0, 8'd17, 8'd0);
    send_number(64'hFFFF_FFFF, 1'b0, 1'b0, 8'd255, 8'd0);
  endtask

  task automatic test_sign_handling();
    send_number(64'h8000_0000, 1'b1, 1'b0, 8'd10, 8'd0);
    send_number(64'h8000_0000_0000_0000, 1'b1, 1'b1, 8'd10, 8'd0);
    send_number('1, 1'b1, 1'b0, 8'd10, 8'd0);
    send_number(64'h7FFF_FFFF, 1'b1, 1'b0, 8'd10, 8'd0);
    send_number(64'hFFFF_FFFF_0000_0005, 1'b1, 1'b0, 8'd10, 8'd0);
    send_number('1, 1'b1, 1'b0, 8'd16, 8'd0);
    send_number(64'h8000_0000, 1'b0, 1'b0, 8'd10, 8'd0);
    send_number(64'h8000_0000, 1'b1, 1'b1, 8'd10, 8'd0);
    // The sign test looks at the radix before clamping.
    send_number(64'hFFFF_FFFF, 1'b1, 1'b0, 8'd0, 8'd0);
  endtask

  task automatic test_width_padding();
    send_number(64'd7, 1'b0, 1'b0, 8'd10, 8'd32);
    send_number(64'd7, 1'b0, 1'b0, 8'd10, 8'd33);
    send_number(64'd7, 1'b0, 1'b1, 8'd10, 8'd64);
    send_number(-64'sd123, 1'b1, 1'b1, 8'd10, 8'd255);
    send_number(64'd123456, 1'b0, 1'b0, 8'd10, 8'd3);
    send_number(64'h8000_0000, 1'b1, 1'b0, 8'd10, 8'd255);
  endtask

  task automatic test_random_numbers(input int unsigned n_items);
    logic [63:0] value;
    logic [7:0]  radix;
    logic [7:0]  min_width;
    for (int i = 0; i < n_items; i++) begin
      idle_on = !(i >= 150 && i < 250);
      if (i == 120 || i == 300) wait_for_drain();
      case ($urandom_range(0, 5))
        0, 1: value = {$urandom, $urandom};
        2: value = 64'($urandom_range(0, 999));
        3: value = {32'hFFFF_FFFF, $urandom};
        4: value = (64'd1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 1));
        default: value = {$urandom, $urandom} >> $urandom_range(0, 63);
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3: radix = itpa_pkg::RADIX_SIGNED;
        4: radix = 8'd2;
        5: radix = 8'd8;
        6: radix = 8'd16;
        default: radix = 8'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: min_width = 8'($urandom_range(0, 16));
        5, 6, 7: min_width = 8'($urandom_range(0, 70));
        default: min_width = 8'($urandom_range(0, 255));
      endcase
      send_number(value, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), radix,
                  min_width);
    end
  endtask

  always @(posedge clk_i) begin
    ascii_char_t exp_c;
    if (rst_ni && strobe_o) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected character transfer: %h last %b", character_o, last_o);
        mismatch_count++;
      end else begin
        exp_c = pending_chars.pop_front();
        if (character_o !== exp_c.code) begin
          $error("character: expected %h, got %h", exp_c.code, character_o);
          mismatch_count++;
        end
        if (last_o !== exp_c.last) begin
          $error("last: expected %b, got %b", exp_c.last, last_o);
          mismatch_count++;
        end
      end
    end
  end

  // Any accepted command or character counts as progress.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || strobe_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_zero_and_extremes();
    test_radix_clamp();
    test_sign_handling();
    test_width_padding();
    wait_for_drain();
    test_random_numbers(RANDOM_ITEMS);
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_chars.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
